// ===== rtl/twtl_pkg.sv =====
// Shared types and constants of the two-way traffic light controller.
package twtl_pkg;

   localparam int GREEN_W = 12;
   localparam int SHORT_W = 8;
   localparam int LAMP_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = GREEN_W;

   localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd0;
   localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd1;
   localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MAX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP      = 3'd3;

   localparam logic [GREEN_W-1:0] GREEN_MAX_RST = 12'd121;
   localparam logic [SHORT_W-1:0] YELLOW_RST    = 8'd5;
   localparam logic [SHORT_W-1:0] THRESHOLD_RST = 8'd5;
   localparam logic [SHORT_W-1:0] WRAP_RST      = 8'd8;

   typedef enum logic [3:0] {
      PH_GREEN1  = 4'b0001,
      PH_YELLOW1 = 4'b0010,
      PH_GREEN2  = 4'b0100,
      PH_YELLOW2 = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [GREEN_W-1:0] green_max;
      logic [SHORT_W-1:0] yellow;
      logic [SHORT_W-1:0] threshold;
      logic [SHORT_W-1:0] wrap;
   } cfg_type;

   typedef struct packed {
      logic [LAMP_W-1:0] light_side1;
      logic [LAMP_W-1:0] light_side2;
      logic              phase_changed;
   } result_type;

endpackage

// ===== rtl/twtl_csr.sv =====
// Configuration register file of the traffic light controller.
module twtl_csr import twtl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GREEN_MAX: cfg_in.green_max = csr_wdata;
            CSR_YELLOW:    cfg_in.yellow    = csr_wdata[SHORT_W-1:0];
            CSR_THRESHOLD: cfg_in.threshold = csr_wdata[SHORT_W-1:0];
            CSR_WRAP:      cfg_in.wrap      = csr_wdata[SHORT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_max <= GREEN_MAX_RST;
         cfg_ff.yellow    <= YELLOW_RST;
         cfg_ff.threshold <= THRESHOLD_RST;
         cfg_ff.wrap      <= WRAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/twtl_step.sv =====
// Phase and hold counter state with the per-tick update logic.
module twtl_step import twtl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       tick,
   input  logic       button_side1,
   input  logic       button_side2,
   output result_type result
);

   phase_type          phase_ff, phase_in;
   logic [GREEN_W-1:0] elapsed_ff, elapsed_in;
   logic [SHORT_W-1:0] hold1_ff, hold1_in;
   logic [SHORT_W-1:0] hold2_ff, hold2_in;
   logic [GREEN_W:0]   next_elapsed;
   logic               advance;

   function automatic logic [SHORT_W-1:0] hold_next(input logic [SHORT_W-1:0] count,
                                                    input logic pressed,
                                                    input logic [SHORT_W-1:0] wrap);
      logic [SHORT_W-1:0] n;
      n = pressed ? count + 1'b1 : '0;
      if (n >= wrap) begin
         n = '0;
      end
      return n;
   endfunction

   always_comb begin
      hold1_in     = hold_next(hold1_ff, button_side1, cfg.wrap);
      hold2_in     = hold_next(hold2_ff, button_side2, cfg.wrap);
      next_elapsed = {1'b0, elapsed_ff} + 1'b1;
      unique case (phase_ff)
         PH_GREEN1: advance = (next_elapsed >= {1'b0, cfg.green_max})
                              || (hold2_in >= cfg.threshold);
         PH_GREEN2: advance = (next_elapsed >= {1'b0, cfg.green_max})
                              || (hold1_in >= cfg.threshold);
         default:   advance = next_elapsed >= {{(GREEN_W-SHORT_W+1){1'b0}}, cfg.yellow};
      endcase

      phase_in   = phase_ff;
      elapsed_in = next_elapsed[GREEN_W-1:0];
      if (advance) begin
         elapsed_in = '0;
         unique case (phase_ff)
            PH_GREEN1:  phase_in = PH_YELLOW1;
            PH_YELLOW1: phase_in = PH_GREEN2;
            PH_GREEN2:  phase_in = PH_YELLOW2;
            PH_YELLOW2: phase_in = PH_GREEN1;
            default:    phase_in = PH_GREEN1;
         endcase
      end

      unique case (phase_in)
         PH_GREEN1: begin
            result.light_side1 = LAMP_GREEN;
            result.light_side2 = LAMP_RED;
         end
         PH_YELLOW1: begin
            result.light_side1 = LAMP_YELLOW;
            result.light_side2 = LAMP_RED;
         end
         PH_GREEN2: begin
            result.light_side1 = LAMP_RED;
            result.light_side2 = LAMP_GREEN;
         end
         default: begin
            result.light_side1 = LAMP_RED;
            result.light_side2 = LAMP_YELLOW;
         end
      endcase
      result.phase_changed = advance;
   end

   // commit state only when a word moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_GREEN1;
         elapsed_ff <= '0;
         hold1_ff   <= '0;
         hold2_ff   <= '0;
      end else if (tick) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         hold1_ff   <= hold1_in;
         hold2_ff   <= hold2_in;
      end
   end

endmodule

// ===== rtl/two_way_traffic_light_controller_core.sv =====
// Top level of the two-way traffic light controller.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_button_side1, req_button_side2
//   rsp      out        rsp_valid / rsp_ready   rsp_light_side1, rsp_light_side2,
//                                               rsp_phase_changed
//   csr      in         csr_write               csr_index, csr_wdata
//
// A tick word is held in the input register, then the state update and its
// result land in the output register, which drives rsp_valid.
// Throughput is one word per cycle while rsp is not stalled; the single state update
// between the two registers sets that figure.
// Synchronous reset clears valids, phase and counters and loads configuration defaults.
// A stalled rsp holds the output register; the input register keeps one more word.
module two_way_traffic_light_controller_core import twtl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_button_side1,
   input  logic                  req_button_side2,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LAMP_W-1:0]     rsp_light_side1,
   output logic [LAMP_W-1:0]     rsp_light_side2,
   output logic                  rsp_phase_changed,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       in_vld_ff, in_vld_in;
   logic       b1_ff, b2_ff;
   logic       out_vld_ff, out_vld_in;
   logic       out_free;
   logic       move;

   twtl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   twtl_step u_step (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .tick         (move),
      .button_side1 (b1_ff),
      .button_side2 (b2_ff),
      .result       (result)
   );

   assign out_free  = !out_vld_ff || rsp_ready;
   assign move      = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;

   always_comb begin
      in_vld_in  = in_vld_ff;
      out_vld_in = out_vld_ff;
      if (req_ready) begin
         in_vld_in = req_valid;
      end
      if (out_free) begin
         out_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         b1_ff <= req_button_side1;
         b2_ff <= req_button_side2;
      end
      if (move) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_light_side1   = rsp_ff.light_side1;
   assign rsp_light_side2   = rsp_ff.light_side2;
   assign rsp_phase_changed = rsp_ff.phase_changed;

endmodule

// ===== rtl/twtl_checker.sv =====
// Port-level checks of the traffic light controller, bound to the top level.
module twtl_checker import twtl_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [LAMP_W-1:0] rsp_light_side1,
   input logic [LAMP_W-1:0] rsp_light_side2,
   input logic              rsp_phase_changed
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_light_side1)
         && $stable(rsp_light_side2) && $stable(rsp_phase_changed))
      else $error("stalled result word changed");

   // at least one side shows red in every valid result word
   a_one_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_light_side1 == LAMP_RED) || (rsp_light_side2 == LAMP_RED))
      else $error("no side is red");

   // no lamp of a valid result word carries the illegal code 3
   a_lamp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_light_side1 != 2'd3) && (rsp_light_side2 != 2'd3))
      else $error("illegal lamp code");

   // no result word straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a word can only show up after one was taken
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) || $past(req_valid, 1))
      else $error("result word without an accepted request");

endmodule

bind two_way_traffic_light_controller_core twtl_checker u_twtl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_light_side1   (rsp_light_side1),
   .rsp_light_side2   (rsp_light_side2),
   .rsp_phase_changed (rsp_phase_changed)
);

// ===== tb/two_way_traffic_light_controller_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the two-way traffic light controller core.
module two_way_traffic_light_controller_core_test;
   import twtl_pkg::*;

   typedef struct packed {
      logic side1;
      logic side2;
   } buttons_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_button_side1 = 1'b0;
   logic                  req_button_side2 = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [LAMP_W-1:0]     rsp_light_side1;
   logic [LAMP_W-1:0]     rsp_light_side2;
   logic                  rsp_phase_changed;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_GREEN_MAX;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   buttons_type tick_queue[$];
   result_type  lamps_due[$];
   int          fail_count = 0;

   // intersection state as the testbench tracks it
   cfg_type            timing = '{GREEN_MAX_RST, YELLOW_RST, THRESHOLD_RST, WRAP_RST};
   phase_type          cur_phase = PH_GREEN1;
   logic [GREEN_W-1:0] phase_ticks = '0;
   logic [SHORT_W-1:0] held1 = '0;
   logic [SHORT_W-1:0] held2 = '0;

   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_cycle = 0;
   int          run1 = 0;
   int          run2 = 0;
   logic        level1 = 1'b0;
   logic        level2 = 1'b0;
   buttons_type next_tick;

   two_way_traffic_light_controller_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_button_side1  (req_button_side1),
      .req_button_side2  (req_button_side2),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_light_side1   (rsp_light_side1),
      .rsp_light_side2   (rsp_light_side2),
      .rsp_phase_changed (rsp_phase_changed),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [SHORT_W-1:0] next_hold(logic [SHORT_W-1:0] count, logic pressed);
      logic [SHORT_W-1:0] bumped;
      bumped = pressed ? count + 1'b1 : '0;
      return (bumped >= timing.wrap) ? '0 : bumped;
   endfunction

   // Advance the intersection by one tick and return the lamps it shows.
   function automatic result_type advance_lights(buttons_type tick);
      result_type lamps;
      logic       done;
      int         next_ticks;
      held1 = next_hold(held1, tick.side1);
      held2 = next_hold(held2, tick.side2);
      next_ticks = int'(phase_ticks) + 1;
      case (cur_phase)
         PH_GREEN1: done = next_ticks >= int'(timing.green_max) || held2 >= timing.threshold;
         PH_GREEN2: done = next_ticks >= int'(timing.green_max) || held1 >= timing.threshold;
         default:   done = next_ticks >= int'(timing.yellow);
      endcase
      if (done) begin
         case (cur_phase)
            PH_GREEN1:  cur_phase = PH_YELLOW1;
            PH_YELLOW1: cur_phase = PH_GREEN2;
            PH_GREEN2:  cur_phase = PH_YELLOW2;
            default:    cur_phase = PH_GREEN1;
         endcase
         phase_ticks = '0;
      end else begin
         phase_ticks = next_ticks[GREEN_W-1:0];
      end
      case (cur_phase)
         PH_GREEN1: begin
            lamps.light_side1 = LAMP_GREEN;
            lamps.light_side2 = LAMP_RED;
         end
         PH_YELLOW1: begin
            lamps.light_side1 = LAMP_YELLOW;
            lamps.light_side2 = LAMP_RED;
         end
         PH_GREEN2: begin
            lamps.light_side1 = LAMP_RED;
            lamps.light_side2 = LAMP_GREEN;
         end
         default: begin
            lamps.light_side1 = LAMP_RED;
            lamps.light_side2 = LAMP_YELLOW;
         end
      endcase
      lamps.phase_changed = done;
      return lamps;
   endfunction

   task automatic check_lamps();
      result_type want;
      if (lamps_due.size() == 0) begin
         $error("result word with no tick outstanding");
         fail_count++;
         return;
      end
      want = lamps_due.pop_front();
      if (rsp_light_side1 !== want.light_side1) begin
         $error("light_side1: expected %0d, actual %0d", want.light_side1, rsp_light_side1);
         fail_count++;
      end
      if (rsp_light_side2 !== want.light_side2) begin
         $error("light_side2: expected %0d, actual %0d", want.light_side2, rsp_light_side2);
         fail_count++;
      end
      if (rsp_phase_changed !== want.phase_changed) begin
         $error("phase_changed: expected %0d, actual %0d", want.phase_changed,
                rsp_phase_changed);
         fail_count++;
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (index)
         CSR_GREEN_MAX: timing.green_max = value[GREEN_W-1:0];
         CSR_YELLOW:    timing.yellow = value[SHORT_W-1:0];
         CSR_THRESHOLD: timing.threshold = value[SHORT_W-1:0];
         CSR_WRAP:      timing.wrap = value[SHORT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Short registers get random junk above bit 7 to check the masking.
   task automatic set_timing(int green, int yellow, int threshold, int wrap);
      write_reg(CSR_GREEN_MAX, green);
      write_reg(CSR_YELLOW, yellow | ($urandom_range(0, 15) << SHORT_W));
      write_reg(CSR_THRESHOLD, threshold | ($urandom_range(0, 15) << SHORT_W));
      write_reg(CSR_WRAP, wrap | ($urandom_range(0, 15) << SHORT_W));
   endtask

   task automatic push_tick(logic side1, logic side2);
      buttons_type tick;
      tick.side1 = side1;
      tick.side2 = side2;
      tick_queue.push_back(tick);
   endtask

   // Mostly held and released runs on each button, with some random noise.
   task automatic push_held(int count);
      buttons_type tick;
      repeat (count) begin
         if (run1 == 0) begin
            level1 = 1'($urandom_range(0, 1));
            run1 = $urandom_range(1, 12);
         end
         if (run2 == 0) begin
            level2 = 1'($urandom_range(0, 1));
            run2 = $urandom_range(1, 12);
         end
         run1--;
         run2--;
         tick.side1 = level1;
         tick.side2 = level2;
         if ($urandom_range(0, 6) == 0)
            tick = buttons_type'(2'($urandom_range(0, 3)));
         tick_queue.push_back(tick);
      end
   endtask

   // Hold off until every tick is through and its lamps have come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || lamps_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_button_side1 <= 1'b0;
         req_button_side2 <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready)
            lamps_due.push_back(advance_lights({req_button_side1, req_button_side2}));
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               next_tick = tick_queue.pop_front();
               req_valid <= 1'b1;
               req_button_side1 <= next_tick.side1;
               req_button_side2 <= next_tick.side2;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_lamps();
         stall_cycle <= stall_cycle + 1;
         case ((stall_cycle / 250) % 4)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 2) != 0);
            2:       rsp_ready <= (stall_cycle % 13) >= 9;
            default: rsp_ready <= ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   initial begin
      int random_items;
      int count;
      int pick;
      random_items = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset timing, every button combination
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b1);
      push_tick(1'b1, 1'b1);
      wait_idle();

      // short timing: early end by either button, wrap of the hold counters
      set_timing(3, 1, 2, 4);
      for (int idx = 4; idx < 8; idx++)
         write_reg(CSR_IDX_W'(idx), 12'hFFF);
      repeat (3) push_tick(1'b0, 1'b1);
      repeat (2) push_tick(1'b0, 1'b0);
      repeat (4) push_tick(1'b1, 1'b0);
      repeat (4) push_tick(1'b1, 1'b1);
      wait_idle();

      // zero lengths, zero threshold, zero wrap
      set_timing(0, 0, 0, 0);
      repeat (3) push_tick(1'b1, 1'b1);
      repeat (3) push_tick(1'b0, 1'b1);
      wait_idle();

      // all registers at their top; later settings cut this green short
      set_timing(12'hFFF, 8'hFF, 8'hFF, 8'hFF);
      repeat (30) push_tick(1'b1, 1'b1);
      wait_idle();

      while (random_items < 670) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: set_timing($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
            1: set_timing($urandom_range(0, 2), $urandom_range(0, 2),
                          $urandom_range(0, 1), $urandom_range(0, 2));
            default: set_timing($urandom_range(1, 12), $urandom_range(1, 4),
                                $urandom_range(0, 7), $urandom_range(0, 10));
         endcase
         write_reg(CSR_IDX_W'($urandom_range(4, 7)), $urandom_range(0, 4095));
         count = $urandom_range(30, 80);
         push_held(count);
         random_items += count;
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && lamps_due.size() == 0)
         $display("** two_way_traffic_light_controller_core: PASSED **");
      else
         $display("** two_way_traffic_light_controller_core: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("** two_way_traffic_light_controller_core: FAILED **");
      $finish;
   end

endmodule
